### rtl/hcp_pkg.sv
// Shared types and constants for the Huffman code table bit packer.
`timescale 1ns / 1ps

package hcp_pkg;

  // Field widths of the input and output words
  localparam int unsigned SymW      = 8;
  localparam int unsigned CodeBitsW = 32;
  localparam int unsigned LenW      = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned InTdataW  = 48;   // symbol + code_bits + code_length, byte padded
  localparam int unsigned CarryW    = 7;    // pending bits kept between bytes

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

endpackage

### rtl/huffman_code_table_bit_packer_top.sv
// Top level of the table-driven Huffman bit packer.
`timescale 1ns / 1ps

// Usage:
//   Slave channel: tuser carries the command (write table entry, encode, flush);
//   tdata carries symbol, code word and code length. A write stores the code word
//   and length for one symbol; encode appends that symbol's code bits, MSB first;
//   flush zero-pads the pending partial byte and sends it with tlast high.
//   Master channel: one packed byte per word, first code bit in bit 7.
// Path: an encode or flush word goes through the table read register, the queue
//   and the packer into the output register before its first byte leaves.
// Throughput: one input word per cycle while the receiver is ready and each encode
//   yields at most one byte; the packer moves one byte per cycle, so a code that
//   yields more than one byte holds the queue while its extra bytes drain.
// Reset: the code table reads as all zero (per-entry valid flops), the bit
//   accumulator is empty and no output is pending.
// Receiver stall: the output register holds its byte; the packer, then the
//   two-entry queue, then the lookup stage fill and tready drops.
module huffman_code_table_bit_packer_top #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned SYMBOL_COUNT  = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  logic [hcp_pkg::InTdataW-1:0] s_axis_tdata,
  // [1:0] command
  input  logic [hcp_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] out_byte
  output logic [hcp_pkg::ByteW-1:0]    m_axis_tdata,
  output logic                         m_axis_tlast  // final_byte
);

  import hcp_pkg::*;

  // Codes are limited to the code_bits field width
  localparam int unsigned CodeW  = (MAX_CODE_BITS < CodeBitsW) ? MAX_CODE_BITS : CodeBitsW;
  localparam int unsigned ItemW  = CodeW + LenW + 1;
  localparam int unsigned QDepth = 2;

  logic             fr_valid, fr_ready, bk_valid, bk_ready;
  logic [ItemW-1:0] fr_item, bk_item;

  hcp_front #(
    .CODE_W       (CodeW),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .sym_i        (s_axis_tdata[SymW-1:0]),
    .bits_i       (s_axis_tdata[SymW+CodeBitsW-1:SymW]),
    .len_i        (s_axis_tdata[SymW+CodeBitsW+LenW-1:SymW+CodeBitsW]),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  hcp_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_item)
  );

  hcp_pack #(
    .CODE_W (CodeW)
  ) u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .last_o       (m_axis_tlast)
  );

endmodule

### rtl/hcp_fifo.sv
// Small register queue between the lookup front end and the packer.
`timescale 1ns / 1ps

module hcp_fifo #(
  parameter int unsigned WIDTH = 39,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/hcp_front.sv
// Front end: accepts words, owns the code table, turns encode/flush into queue items.
`timescale 1ns / 1ps

module hcp_front #(
  parameter int unsigned CODE_W       = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [hcp_pkg::CmdW-1:0]      cmd_i,
  input  logic [hcp_pkg::SymW-1:0]      sym_i,
  input  logic [hcp_pkg::CodeBitsW-1:0] bits_i,
  input  logic [hcp_pkg::LenW-1:0]      len_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  // {flush, length, code word}
  output logic [CODE_W+hcp_pkg::LenW:0] item_o
);

  import hcp_pkg::*;

  localparam int unsigned IdxW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned EntW  = LenW + CODE_W;

  logic [EntW-1:0]         tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tbl_vld_q;
  logic [EntW-1:0]         rd_q;
  logic                    rd_vld_q;
  logic                    s1_valid_q, s1_valid_d, s1_flush_q;

  logic                 accept, in_range, wr_en, rd_en, load, pop;
  logic [IdxW-1:0]      idx;
  logic [LenW-1:0]      len_sat;
  logic [CodeBitsW-1:0] mask;
  cmd_e                 cmd;

  assign cmd      = cmd_e'(cmd_i);
  assign idx      = sym_i[IdxW-1:0];
  assign in_range = ({1'b0, sym_i} < 9'(SYMBOL_COUNT));
  assign pop      = s1_valid_q & item_ready_i;
  assign s_ready_o = !s1_valid_q | item_ready_i;
  assign accept   = s_valid_i & s_ready_o;

  // Long lengths saturate at the code width; stray bits above the length drop.
  assign len_sat = (len_i > LenW'(CODE_W)) ? LenW'(CODE_W) : len_i;
  assign mask    = ~({CodeBitsW{1'b1}} << len_sat);

  always_comb begin
    wr_en = 1'b0;
    rd_en = 1'b0;
    load  = 1'b0;
    unique case (cmd)
      CMD_WRITE:  wr_en = accept & in_range;
      CMD_ENCODE: begin
        rd_en = accept & in_range;
        load  = accept & in_range;
      end
      CMD_FLUSH:  load = accept;
      default:    load = 1'b0;
    endcase
  end

  assign s1_valid_d = load | (s1_valid_q & !pop);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[idx] <= {len_sat, CODE_W'(bits_i & mask)};
    end
    if (rd_en) begin
      rd_q <= tbl_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      if (wr_en) begin
        tbl_vld_q[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= tbl_vld_q[idx];
      end
      if (load) begin
        s1_flush_q <= (cmd == CMD_FLUSH);
      end
      s1_valid_q <= s1_valid_d;
    end
  end

  // Entries never written read as zero length, zero code.
  assign item_valid_o = s1_valid_q;
  assign item_o       = {s1_flush_q, rd_vld_q ? rd_q : EntW'(0)};

endmodule

### rtl/hcp_pack.sv
// Back end: bit accumulator that merges code words and emits bytes through an output register.
`timescale 1ns / 1ps

module hcp_pack #(
  parameter int unsigned CODE_W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  logic [CODE_W+hcp_pkg::LenW:0] item_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [hcp_pkg::ByteW-1:0]     byte_o,
  output logic                          last_o
);

  import hcp_pkg::*;

  localparam int unsigned AccW = CODE_W + CarryW;
  localparam int unsigned CntW = $clog2(AccW + 1);

  logic [AccW-1:0]   acc_q, acc_d, m_acc;
  logic [CntW-1:0]   cnt_q, cnt_d, m_cnt, sh;
  logic [CarryW-1:0] low7;
  logic              ovalid_q, olast_q;
  logic [ByteW-1:0]  obyte_q;

  logic              in_flush, out_free, pop, emit, emit_last;
  logic [LenW-1:0]   in_len;
  logic [CODE_W-1:0] in_word;
  logic [ByteW-1:0]  emit_byte;

  assign in_flush = item_i[CODE_W+LenW];
  assign in_len   = item_i[CODE_W+LenW-1:CODE_W];
  assign in_word  = item_i[CODE_W-1:0];
  assign out_free = !ovalid_q | m_ready_i;

  // Pending bits (fewer than a byte) merged with the next code word
  assign low7  = acc_q[CarryW-1:0] & ~({CarryW{1'b1}} << cnt_q[2:0]);
  assign m_acc = (AccW'(low7) << in_len) | AccW'(in_word);
  assign m_cnt = CntW'(cnt_q[2:0]) + CntW'(in_len);

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = '0;
    sh        = '0;
    if (cnt_q >= CntW'(ByteW)) begin
      // drain whole bytes left from a long code
      if (out_free) begin
        emit      = 1'b1;
        sh        = cnt_q - CntW'(ByteW);
        emit_byte = ByteW'(acc_q >> sh);
        cnt_d     = sh;
      end
    end else if (item_valid_i) begin
      if (in_flush) begin
        if (cnt_q[2:0] == 3'd0) begin
          pop = 1'b1;
        end else if (out_free) begin
          pop       = 1'b1;
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_byte = {1'b0, low7} << (4'd8 - {1'b0, cnt_q[2:0]});
          cnt_d     = '0;
        end
      end else if (m_cnt >= CntW'(ByteW)) begin
        if (out_free) begin
          pop       = 1'b1;
          emit      = 1'b1;
          sh        = m_cnt - CntW'(ByteW);
          emit_byte = ByteW'(m_acc >> sh);
          acc_d     = m_acc;
          cnt_d     = sh;
        end
      end else begin
        pop   = 1'b1;
        acc_d = m_acc;
        cnt_d = m_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (emit) begin
        ovalid_q <= 1'b1;
        olast_q  <= emit_last;
      end else if (m_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (emit) begin
      obyte_q <= emit_byte;
    end
  end

  assign item_ready_o = pop;
  assign m_valid_o    = ovalid_q;
  assign byte_o       = obyte_q;
  assign last_o       = olast_q;

endmodule

### tb/tb_huffman_code_table_bit_packer_top.sv
// Self-checking testbench for the Huffman code table bit packer top level.
`timescale 1ns / 1ps

module tb_huffman_code_table_bit_packer_top;

  import hcp_pkg::*;

  localparam int unsigned MaxCodeBits = 32;
  localparam int unsigned SymbolCount = 256;
  localparam int unsigned CodeLimit   = (MaxCodeBits < 32) ? MaxCodeBits : 32;
  localparam int unsigned RandWords   = 470;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;     // well past the output latency
  localparam int unsigned IdlePct     = 12;
  // Command code the block has no use for; it must be swallowed silently
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CmdW-1:0]      cmd;
    logic [SymW-1:0]      sym;
    logic [CodeBitsW-1:0] code;
    logic [LenW-1:0]      len;
  } packer_word_t;

  typedef struct {
    logic [ByteW-1:0] out_byte;
    logic             final_byte;
  } packed_byte_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ByteW-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;

  huffman_code_table_bit_packer_top #(
    .MAX_CODE_BITS(MaxCodeBits),
    .SYMBOL_COUNT (SymbolCount)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Words waiting to go out, and bytes the packer still owes us
  packer_word_t word_q[$];
  packed_byte_t packed_bytes_q[$];
  packer_word_t cur_word;

  // Shadow copy of the block's code table and bit carry
  logic [CodeBitsW-1:0] shadow_code[SymbolCount];
  int unsigned          shadow_len[SymbolCount];
  logic [CarryW-1:0]    carry_bits = '0;
  int unsigned          carry_cnt  = 0;

  int unsigned n_words = 0;
  int unsigned n_write = 0, n_encode = 0, n_flush = 0, n_unused = 0;
  int unsigned n_bytes = 0, n_tlast = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle   = 0;
  logic        quiet;

  // Neither side idles while this stretch of words goes through
  assign quiet = (n_words >= 200) && (n_words < 320);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Update the shadow state for one accepted word and queue the bytes it yields
  task automatic pack_word(input packer_word_t w);
    logic [63:0]          acc;
    logic [CodeBitsW-1:0] code;
    logic [ByteW-1:0]     pad;
    packed_byte_t         pb;
    int unsigned          clen, total, n;
    begin
      n = 0;
      case (w.cmd)
        CMD_WRITE: begin
          n_write++;
          if (w.sym < SymbolCount) begin
            clen = (w.len > CodeLimit) ? CodeLimit : w.len;
            code = w.code;
            if (clen < 32) code &= (32'd1 << clen) - 32'd1;
            shadow_code[w.sym] = code;
            shadow_len[w.sym]  = clen;
          end
        end
        CMD_ENCODE: begin
          n_encode++;
          if (w.sym < SymbolCount) begin
            clen  = shadow_len[w.sym];
            acc   = ({57'd0, carry_bits} << clen) | {32'd0, shadow_code[w.sym]};
            total = carry_cnt + clen;
            while (total >= 8 && n < 4) begin
              pb.out_byte   = acc[total-1 -: 8];
              pb.final_byte = 1'b0;
              packed_bytes_q.push_back(pb);
              n++;
              total -= 8;
            end
            carry_cnt  = total % 8;
            carry_bits = CarryW'(acc & ((64'd1 << carry_cnt) - 64'd1));
          end
        end
        CMD_FLUSH: begin
          n_flush++;
          if (carry_cnt != 0) begin
            // zero fill below the pending bits
            pad           = {1'b0, carry_bits} << (8 - carry_cnt);
            pb.out_byte   = pad;
            pb.final_byte = 1'b1;
            packed_bytes_q.push_back(pb);
            carry_bits = '0;
            carry_cnt  = 0;
          end
        end
        default: n_unused++;
      endcase
    end
  endtask

  // Driver: present the next pending word once the previous one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pack_word(cur_word);
        n_words++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() > 0 && (quiet || $urandom_range(99) >= IdlePct)) begin
          cur_word = word_q.pop_front();
          s_axis_tdata  <= {2'b00, cur_word.len, cur_word.code, cur_word.sym};
          s_axis_tuser  <= cur_word.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back pressure, each accepted byte checked against the oldest owed
  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_bytes++;
        if (m_axis_tlast) n_tlast++;
        if (packed_bytes_q.size() == 0) begin
          $error("unexpected byte: out_byte=%02h final_byte=%0b", m_axis_tdata,
                 m_axis_tlast);
          err_cnt++;
        end else begin
          want = packed_bytes_q.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tlast !== want.final_byte) begin
            $error("final_byte: expected %0b, got %0b", want.final_byte, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle,
               packed_bytes_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void add_word(input logic [CmdW-1:0] cmd, input logic [SymW-1:0] sym,
                                   input logic [CodeBitsW-1:0] code,
                                   input logic [LenW-1:0] len);
    packer_word_t w;
    w.cmd  = cmd;
    w.sym  = sym;
    w.code = code;
    w.len  = len;
    word_q.push_back(w);
  endfunction

  // Mostly short codes, some long ones, a few over the limit or empty
  function automatic logic [LenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return LenW'($urandom_range(12, 1));
    if (r < 88) return LenW'($urandom_range(32, 13));
    if (r < 95) return LenW'($urandom_range(63, 33));
    return '0;
  endfunction

  initial begin
    logic [SymW-1:0] live_syms[$];
    logic [SymW-1:0] s;
    int unsigned     r, made;

    for (int i = 0; i < SymbolCount; i++) begin
      shadow_code[i] = '0;
      shadow_len[i]  = 0;
    end

    // Directed: empty table, empty flush, unused command
    add_word(CMD_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
    add_word(CMD_FLUSH, 8'd0, '0, '0);
    add_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Table extremes: full width, stray high bits, over-limit length, zero length
    add_word(CMD_WRITE, 8'd0, 32'hFFFF_FFFF, 6'd32);
    add_word(CMD_WRITE, 8'd255, 32'hFFFF_FFF5, 6'd3);
    add_word(CMD_WRITE, 8'd1, 32'h0000_0000, 6'd63);
    add_word(CMD_WRITE, 8'd2, 32'hA5A5_A5A5, 6'd0);
    add_word(CMD_WRITE, 8'd128, 32'h0000_0001, 6'd1);
    add_word(CMD_WRITE, 8'd3, 32'hFFFF_FF55, 6'd7);
    add_word(CMD_WRITE, 8'd4, 32'h8000_0001, 6'd40);
    add_word(CMD_ENCODE, 8'd255, '0, '0);
    add_word(CMD_ENCODE, 8'd0, '0, '0);
    add_word(CMD_ENCODE, 8'd1, '0, '0);
    add_word(CMD_ENCODE, 8'd2, '0, '0);
    add_word(CMD_FLUSH, 8'd0, '0, '0);
    add_word(CMD_FLUSH, 8'd0, '0, '0);
    // Seven bits pending, then a full 32-bit code: four bytes out, seven left
    add_word(CMD_ENCODE, 8'd3, '0, '0);
    add_word(CMD_ENCODE, 8'd0, '0, '0);
    add_word(CMD_ENCODE, 8'd128, '0, '0);
    add_word(CMD_ENCODE, 8'd4, '0, '0);
    add_word(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Rewrite over a live entry, then use it right away
    add_word(CMD_WRITE, 8'd0, 32'h0000_0002, 6'd2);
    add_word(CMD_ENCODE, 8'd0, '0, '0);
    add_word(CMD_FLUSH, 8'd0, '0, '0);

    // Random: seed a table, then mostly encodes of live symbols
    made = 0;
    for (int i = 0; i < 32; i++) begin
      s = SymW'($urandom_range(255));
      add_word(CMD_WRITE, s, $urandom, pick_len());
      live_syms.push_back(s);
      made++;
    end
    while (made < RandWords) begin
      r = $urandom_range(99);
      if (r < 12) begin
        s = SymW'($urandom_range(255));
        add_word(CMD_WRITE, s, $urandom, pick_len());
        live_syms.push_back(s);
        made++;
      end else if (r < 82) begin
        s = live_syms[$urandom_range(live_syms.size() - 1)];
        add_word(CMD_ENCODE, s, $urandom, LenW'($urandom_range(63)));
        made++;
      end else if (r < 86) begin
        add_word(CMD_ENCODE, SymW'($urandom_range(255)), $urandom, LenW'($urandom_range(63)));
        made++;
      end else if (r < 96) begin
        add_word(CMD_FLUSH, SymW'($urandom_range(255)), $urandom, LenW'($urandom_range(63)));
        made++;
      end else begin
        add_word(CMD_UNUSED, SymW'($urandom_range(255)), $urandom,
                 LenW'($urandom_range(63)));
        made++;
      end
    end
    add_word(CMD_FLUSH, 8'd0, '0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() > 0 || s_axis_tvalid || packed_bytes_q.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (packed_bytes_q.size() > 0) begin
      $error("%0d expected bytes never arrived", packed_bytes_q.size());
      err_cnt++;
    end

    $display("Sent %0d words: %0d table writes, %0d encodes, %0d flushes, %0d unused.",
             n_words, n_write, n_encode, n_flush, n_unused);
    $display("Checked %0d packed bytes, %0d of them closing a frame; %0d errors.",
             n_bytes, n_tlast, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
